// ===== hdl/sha256_message_hasher_core_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Shared macros for the concurrent checks of the hasher core.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH

// Check that is suspended while reset is asserted.
`define SMH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define SMH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/smh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Transfer types, sequencer encodings, round constants and the SHA-256
// bit-mixing functions.
// ----------------------------------------------------------------------------
package smh_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        is_last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_DATA,
    PH_PAD80,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } phase_e;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [2:0] MAX_BYTES = 3'd4;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== hdl/sha256_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Streams a message in as big-endian words and returns its SHA-256 digest as
// eight words once the final word has been taken.
// ----------------------------------------------------------------------------
// An input transfer is taken only while the core is idle. Each word then moves
// its valid bytes into the 64-byte block buffer at one byte per cycle, except
// while a filled block is being compressed. Every filled block takes 64 rounds
// through the single round unit, then a fold of the working words into the
// chaining words; the working words load on the cycle that pushes the last byte
// of the block. A final word also pushes 9 to 72 padding and length bytes at
// one per cycle outside the one or two compressions this needs, plus a step to
// leave the zero fill and one to finish, after which the eight digest words are
// offered in order, one per cycle unless the receiver stalls.
`include "sha256_message_hasher_core_defines.svh"

module sha256_message_hasher_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  smh_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output smh_pkg::out_t out_data_o
);

  smh_pkg::state_e state_q, state_d;
  smh_pkg::phase_e phase_q;

  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic        last_q;
  logic [2:0]  idx_q;
  logic [5:0]  pos_q;
  logic [63:0] byte_count_q;
  logic [5:0]  round_q;
  logic [2:0]  emit_idx_q;

  logic [31:0] w_q     [16];
  logic [31:0] v_q     [8];
  logic [31:0] chain_q [8];

  logic        push_en;
  logic [7:0]  push_byte;
  logic [63:0] bit_len;
  logic [7:0]  data_byte;
  logic [7:0]  len_byte;
  logic        in_xfer;
  logic        out_xfer;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] choose;
  logic [31:0] major;

  assign bit_len   = {byte_count_q[60:0], 3'b000};
  assign data_byte = word_q[{~idx_q[1:0], 3'b000} +: 8];
  assign len_byte  = bit_len[{~idx_q, 3'b000} +: 8];
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_o && !out_stall_i;

  assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1     = v_q[7] + smh_pkg::big_sigma1(v_q[4]) + choose
                  + smh_pkg::K_ROUND[round_q] + w_q[0];
  assign t2     = smh_pkg::big_sigma0(v_q[0]) + major;
  assign w_new  = smh_pkg::small_sigma1(w_q[14]) + w_q[9]
                  + smh_pkg::small_sigma0(w_q[1]) + w_q[0];

  assign out_data_o.digest_word  = chain_q[emit_idx_q];
  assign out_data_o.digest_index = emit_idx_q;
  assign out_data_o.digest_last  = (emit_idx_q == 3'd7);

  always_comb begin
    push_en     = 1'b0;
    push_byte   = 8'd0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      smh_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      smh_pkg::ST_PUSH: begin
        case (phase_q)
          smh_pkg::PH_DATA: begin
            push_en   = (idx_q < cnt_q);
            push_byte = data_byte;
          end
          smh_pkg::PH_PAD80: begin
            push_en   = 1'b1;
            push_byte = smh_pkg::PAD_BYTE;
          end
          smh_pkg::PH_ZERO: begin
            push_en = (pos_q != smh_pkg::LEN_POS);
          end
          smh_pkg::PH_LEN: begin
            push_en   = 1'b1;
            push_byte = len_byte;
          end
          default: begin
            push_en = 1'b0;
          end
        endcase
      end
      smh_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      smh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = smh_pkg::ST_PUSH;
        end
      end
      smh_pkg::ST_PUSH: begin
        if (push_en && pos_q == 6'd63) begin
          state_d = smh_pkg::ST_ROUND;
        end else if (phase_q == smh_pkg::PH_DATA && !push_en && !last_q) begin
          state_d = smh_pkg::ST_IDLE;
        end else if (phase_q == smh_pkg::PH_DONE) begin
          state_d = smh_pkg::ST_EMIT;
        end
      end
      smh_pkg::ST_ROUND: begin
        if (round_q == 6'd63) begin
          state_d = smh_pkg::ST_FOLD;
        end
      end
      smh_pkg::ST_FOLD: begin
        state_d = smh_pkg::ST_PUSH;
      end
      smh_pkg::ST_EMIT: begin
        if (out_xfer && emit_idx_q == 3'd7) begin
          state_d = smh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= smh_pkg::ST_IDLE;
      phase_q      <= smh_pkg::PH_DATA;
      idx_q        <= 3'd0;
      pos_q        <= 6'd0;
      byte_count_q <= 64'd0;
      round_q      <= 6'd0;
      emit_idx_q   <= 3'd0;
      chain_q      <= smh_pkg::IV;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        phase_q <= smh_pkg::PH_DATA;
        idx_q   <= 3'd0;
      end
      if (push_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (state_q == smh_pkg::ST_PUSH) begin
        case (phase_q)
          smh_pkg::PH_DATA: begin
            if (push_en) begin
              idx_q        <= idx_q + 3'd1;
              byte_count_q <= byte_count_q + 64'd1;
            end else if (last_q) begin
              phase_q <= smh_pkg::PH_PAD80;
            end
          end
          smh_pkg::PH_PAD80: begin
            phase_q <= smh_pkg::PH_ZERO;
          end
          smh_pkg::PH_ZERO: begin
            if (!push_en) begin
              phase_q <= smh_pkg::PH_LEN;
              idx_q   <= 3'd0;
            end
          end
          smh_pkg::PH_LEN: begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              phase_q <= smh_pkg::PH_DONE;
            end
          end
          default: begin
            phase_q <= phase_q;
          end
        endcase
      end
      if (state_q == smh_pkg::ST_PUSH && state_d == smh_pkg::ST_ROUND) begin
        round_q <= 6'd0;
      end else if (state_q == smh_pkg::ST_ROUND) begin
        round_q <= round_q + 6'd1;
      end
      if (state_q == smh_pkg::ST_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + v_q[i];
        end
      end
      if (out_xfer) begin
        emit_idx_q <= emit_idx_q + 3'd1;
        if (emit_idx_q == 3'd7) begin
          chain_q      <= smh_pkg::IV;
          byte_count_q <= 64'd0;
          pos_q        <= 6'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q <= in_data_i.data_word;
      cnt_q  <= (in_data_i.valid_bytes > smh_pkg::MAX_BYTES) ? smh_pkg::MAX_BYTES
                                                           : in_data_i.valid_bytes;
      last_q <= in_data_i.is_last;
    end
    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
      end
      w_q[15] <= {w_q[15][23:0], push_byte};
    end else if (state_q == smh_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
    end
    if (state_q == smh_pkg::ST_PUSH && state_d == smh_pkg::ST_ROUND) begin
      v_q <= chain_q;
    end else if (state_q == smh_pkg::ST_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  `SMH_ASSERT(a_emit_blocks_input, clk_i, rst_ni,
              out_valid_o |-> in_stall_o, "Input taken while digest is pending")
  `SMH_ASSERT(a_ready_after_digest, clk_i, rst_ni,
              (out_xfer && out_data_o.digest_last) |=> !in_stall_o,
              "Core not ready after final digest transfer")
  `SMH_ASSERT(a_rounds_then_fold, clk_i, rst_ni,
              (state_q == smh_pkg::ST_ROUND && round_q == 6'd63)
              |=> state_q == smh_pkg::ST_FOLD, "Compression did not end after 64 rounds")
  `SMH_ASSERT(a_emit_block_aligned, clk_i, rst_ni,
              out_valid_o |-> (pos_q == 6'd0), "Digest offered with a partial block")
  `SMH_ASSERT(a_accept_starts_push, clk_i, rst_ni,
              in_xfer |=> state_q == smh_pkg::ST_PUSH, "Input transfer did not start work")
  `SMH_ASSERT_ALWAYS(a_reset_idle, clk_i,
                     !rst_ni |=> (state_q == smh_pkg::ST_IDLE && !out_valid_o),
                     "Core not idle during reset")

endmodule
